/* hw/rtl/tts_pkg.sv */
// Shared types and codes for the text terminal scrollback block.
`default_nettype none
package tts_pkg;
	localparam logic [2:0] REQ_WRITE = 3'd0;
	localparam logic [2:0] REQ_BACKSPACE = 3'd1;
	localparam logic [2:0] REQ_SCROLL = 3'd2;
	localparam logic [2:0] REQ_READ = 3'd3;
	localparam logic [2:0] REQ_CLEAR = 3'd4;

	localparam logic [2:0] KEY_PGUP = 3'd0;
	localparam logic [2:0] KEY_PGDN = 3'd1;
	localparam logic [2:0] KEY_UP = 3'd2;
	localparam logic [2:0] KEY_DOWN = 3'd3;
	localparam logic [2:0] KEY_HOME = 3'd4;
	localparam logic [2:0] KEY_END = 3'd5;

	localparam logic [7:0] BLANK_CHAR = 8'h20;
	localparam logic [7:0] NEWLINE_CODE = 8'd10;
	localparam logic [7:0] RESET_ATTR = 8'h07;
	localparam int PAGE_STEP = 10;

	// One queued request as handed from the front end to the back end.
	typedef struct packed {
		logic [2:0] req_type;
		logic [7:0] char_code;
		logic [2:0] scroll_key;
		logic       ctrl_held;
		logic [4:0] view_row;
		logic [6:0] view_col;
		logic       row_ok;
		logic       is_newline;
	} req_t;
endpackage
`default_nettype wire

/* hw/rtl/tts_front.sv */
// Front end: takes requests, classifies them and queues them for the back end.
`default_nettype none
module tts_front
	import tts_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25,
	parameter int DEPTH = 2
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [2:0] req_type,
	input  wire logic [7:0] char_code,
	input  wire logic [2:0] scroll_key,
	input  wire logic       ctrl_held,
	input  wire logic [4:0] view_row,
	input  wire logic [6:0] view_col,
	output logic            q_valid,
	output req_t            q_data,
	input  wire logic       q_take
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	req_t          fifo_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push, pop;
	req_t          item;

	// Classify the incoming request.
	always_comb begin
		item.req_type = req_type;
		item.char_code = char_code;
		item.scroll_key = scroll_key;
		item.ctrl_held = ctrl_held;
		item.view_row = view_row;
		item.view_col = view_col;
		item.row_ok = (32'(view_row) < ROWS) && (32'(view_col) < COLUMNS);
		item.is_newline = (char_code == NEWLINE_CODE);
	end

	assign in_stall = (32'(count_q) == DEPTH);
	assign push = in_valid && !in_stall;
	assign pop = q_take && q_valid;
	assign q_valid = (count_q != '0);
	assign q_data = fifo_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= item;
		end
	end

	// Queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= DEPTH) else $error("queue count overflow");
	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(count_q) == DEPTH) |-> !push) else $error("push into full queue");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1) else $error("count step");
endmodule
`default_nettype wire

/* hw/rtl/tts_back.sv */
// Back end: carries out requests against the cell memory and holds terminal state.
`default_nettype none
module tts_back
	import tts_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25,
	parameter int HISTORY_LINES = 100
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [7:0]  attr,
	input  wire logic        q_valid,
	input  wire req_t        q_data,
	output logic             q_take,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       cell_char,
	output logic [7:0]       cell_attr,
	output logic [10:0]      cursor_pos,
	output logic             cursor_visible,
	output logic [6:0]       scroll_offset,
	output logic             scrolled_back,
	output logic             busy
);
	localparam int TOTAL = HISTORY_LINES + ROWS;
	localparam int CELLS = TOTAL * COLUMNS;
	localparam int LW = $clog2(TOTAL + 1);
	localparam int CLW = $clog2(COLUMNS + 1);
	localparam int AW = $clog2(CELLS);
	localparam int RW = $clog2(ROWS);
	localparam int SW = $clog2(HISTORY_LINES + 1);

	typedef enum logic [2:0] {
		ST_INIT, ST_IDLE, ST_BLANK, ST_ADDR, ST_RD, ST_OUT
	} state_t;

	state_t         state_q;
	logic [15:0]    mem [CELLS];
	logic [AW-1:0]  sweep_q;
	logic [AW-1:0]  sweep_end_q;
	logic [AW-1:0]  rd_addr_q;
	logic [15:0]    rd_data_q;
	logic [LW-1:0]  newest_q, used_q;
	logic [SW-1:0]  scroll_q;
	logic [CLW-1:0] col_q;
	logic [RW-1:0]  row_q;
	logic           hist_q;
	logic           put_pending_q;
	logic [7:0]     put_char_q;
	logic [15:0]    wipe_word_q;
	logic           read_ok_q;
	req_t           cur_q;
	logic [AW-1:0]  line_base_q;

	logic [LW-1:0]  next_line;
	logic [LW-1:0]  limit;
	logic           mem_we;
	logic [AW-1:0]  mem_wa;
	logic [15:0]    mem_wd;
	logic [LW+1:0]  start_sum;
	logic [LW-1:0]  win_start;
	logic [LW:0]    view_sum;
	logic [LW-1:0]  view_line;

	assign next_line = (32'(newest_q) == TOTAL - 1) ? '0 : newest_q + 1'b1;
	assign limit = (32'(used_q) > ROWS) ? used_q - LW'(ROWS) : '0;
	assign busy = (state_q != ST_IDLE);
	assign q_take = (state_q == ST_IDLE) && q_valid;

	// Window start and the addressed ring line of a read.
	always_comb begin
		start_sum = (LW+2)'(newest_q) + (LW+2)'(TOTAL + 1 - ROWS) - (LW+2)'(scroll_q);
		if (32'(start_sum) >= TOTAL) begin
			start_sum = start_sum - (LW+2)'(TOTAL);
		end
		win_start = (32'(used_q) <= ROWS) ? '0 : start_sum[LW-1:0];
		view_sum = (LW+1)'(win_start) + (LW+1)'(cur_q.view_row);
		if (32'(view_sum) >= TOTAL) begin
			view_sum = view_sum - (LW+1)'(TOTAL);
		end
		view_line = view_sum[LW-1:0];
	end

	// Memory write port shared by the sweep and single cell writes.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = sweep_q;
		mem_wd = wipe_word_q;
		if (state_q == ST_INIT || state_q == ST_BLANK) begin
			mem_we = 1'b1;
		end else if (state_q == ST_ADDR && put_pending_q) begin
			mem_we = 1'b1;
			mem_wa = rd_addr_q;
			mem_wd = {attr, put_char_q};
		end
	end

	// Cell memory with registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_data_q <= mem[rd_addr_q];
	end

	// Sequencer and terminal state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			sweep_q <= '0;
			sweep_end_q <= AW'(CELLS - 1);
			wipe_word_q <= {RESET_ATTR, BLANK_CHAR};
			newest_q <= '0;
			used_q <= LW'(1);
			scroll_q <= '0;
			col_q <= '0;
			row_q <= '0;
			hist_q <= 1'b0;
			put_pending_q <= 1'b0;
			put_char_q <= '0;
			rd_addr_q <= '0;
			line_base_q <= '0;
			cur_q <= '0;
			out_valid <= 1'b0;
			read_ok_q <= 1'b0;
			cell_char <= '0;
			cell_attr <= '0;
			cursor_pos <= '0;
			cursor_visible <= 1'b0;
			scroll_offset <= '0;
			scrolled_back <= 1'b0;
		end else begin
			case (state_q)
				// Clearing sweep over the whole store after reset or clear.
				ST_INIT: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == sweep_end_q) begin
						// Only a clear request waits for a result; the pass after reset does not.
						state_q <= (cur_q.req_type == REQ_CLEAR) ? ST_ADDR : ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_valid) begin
						cur_q <= q_data;
						read_ok_q <= (q_data.req_type == REQ_READ) && q_data.row_ok;
						put_pending_q <= 1'b0;
						state_q <= ST_ADDR;
						case (q_data.req_type)
							REQ_WRITE: begin
								if (q_data.is_newline || 32'(col_q) >= COLUMNS) begin
									// Advance the ring and blank the new line.
									newest_q <= next_line;
									if (32'(used_q) < TOTAL) begin
										used_q <= used_q + 1'b1;
										row_q <= (32'(used_q) < ROWS) ? RW'(used_q) : RW'(ROWS - 1);
									end else begin
										row_q <= RW'(ROWS - 1);
									end
									col_q <= q_data.is_newline ? '0 : CLW'(1);
									hist_q <= 1'b0;
									scroll_q <= '0;
									sweep_q <= AW'(32'(next_line) * COLUMNS);
									line_base_q <= AW'(32'(next_line) * COLUMNS);
									sweep_end_q <= AW'(32'(next_line) * COLUMNS + COLUMNS - 1);
									wipe_word_q <= {attr, BLANK_CHAR};
									put_pending_q <= !q_data.is_newline;
									put_char_q <= q_data.char_code;
									rd_addr_q <= AW'(32'(next_line) * COLUMNS);
									state_q <= ST_BLANK;
								end else begin
									put_pending_q <= 1'b1;
									put_char_q <= q_data.char_code;
									rd_addr_q <= AW'(32'(newest_q) * COLUMNS + 32'(col_q));
									col_q <= col_q + 1'b1;
								end
							end
							REQ_BACKSPACE: begin
								if (col_q != '0) begin
									put_pending_q <= 1'b1;
									put_char_q <= BLANK_CHAR;
									rd_addr_q <= AW'(32'(newest_q) * COLUMNS + 32'(col_q) - 1);
									col_q <= col_q - 1'b1;
								end
							end
							REQ_SCROLL: begin
								case (q_data.scroll_key)
									KEY_PGUP: begin
										if (limit != '0) begin
											hist_q <= 1'b1;
											scroll_q <= (32'(scroll_q) + PAGE_STEP <= 32'(limit))
												? scroll_q + SW'(PAGE_STEP) : SW'(limit);
										end
									end
									KEY_PGDN: begin
										if (hist_q) begin
											if (32'(scroll_q) >= PAGE_STEP) begin
												scroll_q <= scroll_q - SW'(PAGE_STEP);
											end else begin
												scroll_q <= '0;
												hist_q <= 1'b0;
											end
										end
									end
									KEY_UP: begin
										if (q_data.ctrl_held && limit != '0) begin
											hist_q <= 1'b1;
											if (LW'(scroll_q) < limit) begin
												scroll_q <= scroll_q + 1'b1;
											end
										end
									end
									KEY_DOWN: begin
										if (q_data.ctrl_held && hist_q) begin
											if (scroll_q != '0) begin
												scroll_q <= scroll_q - 1'b1;
											end else begin
												hist_q <= 1'b0;
											end
										end
									end
									KEY_HOME: begin
										if (q_data.ctrl_held && limit != '0) begin
											hist_q <= 1'b1;
											scroll_q <= SW'(limit);
										end
									end
									KEY_END: begin
										if (q_data.ctrl_held && hist_q) begin
											hist_q <= 1'b0;
											scroll_q <= '0;
										end
									end
									default: begin
									end
								endcase
							end
							REQ_CLEAR: begin
								newest_q <= '0;
								used_q <= LW'(1);
								scroll_q <= '0;
								col_q <= '0;
								row_q <= '0;
								hist_q <= 1'b0;
								sweep_q <= '0;
								sweep_end_q <= AW'(CELLS - 1);
								wipe_word_q <= {attr, BLANK_CHAR};
								state_q <= ST_INIT;
							end
							default: begin
							end
						endcase
					end
				end
				// Blank the newly opened line, one cell a cycle.
				ST_BLANK: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == sweep_end_q) begin
						rd_addr_q <= line_base_q;
						state_q <= ST_ADDR;
					end
				end
				// Pending cell write lands here; reads form their address.
				ST_ADDR: begin
					put_pending_q <= 1'b0;
					rd_addr_q <= AW'(32'(view_line) * COLUMNS + 32'(cur_q.view_col));
					state_q <= ST_RD;
				end
				ST_RD: begin
					state_q <= ST_OUT;
				end
				// Present the result and hold it until taken.
				ST_OUT: begin
					if (!out_valid) begin
						out_valid <= 1'b1;
						cell_char <= read_ok_q ? rd_data_q[7:0] : 8'd0;
						cell_attr <= read_ok_q ? rd_data_q[15:8] : 8'd0;
						cursor_pos <= 11'(32'(row_q) * COLUMNS + 32'(col_q));
						cursor_visible <= !hist_q;
						scroll_offset <= 7'(scroll_q);
						scrolled_back <= hist_q;
					end else if (!out_stall) begin
						out_valid <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |-> !out_valid) else $error("take while result pending");
	a_scroll_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(scroll_q != '0) |-> hist_q) else $error("scrolled without history mode");
	a_scroll_lim: assert property (@(posedge clk) disable iff (!arst_n)
		32'(scroll_q) <= HISTORY_LINES) else $error("scroll beyond history");
	a_col_lim: assert property (@(posedge clk) disable iff (!arst_n)
		32'(col_q) <= COLUMNS) else $error("cursor column out of range");
endmodule
`default_nettype wire

/* hw/rtl/text_terminal_scrollback_top.sv */
// Top level of the text terminal with scrollback ring.
//
// Requests enter on the in channel (in_valid/in_stall) with the six
// request fields; each request gives exactly one result on the out
// channel (out_valid/out_stall). A two-entry queue separates the request
// front end from the back end that owns the cell memory.
// Sequence: an accepted request is registered in the queue before the
// back end can take it, and the back end takes a request only in its idle
// state. Reads, writes, backspace and scroll then pass through ST_ADDR,
// ST_RD and ST_OUT, where the result is registered; the back end takes no
// new request until the result is accepted. A newline or a write into a
// full line first blanks the new line in ST_BLANK, one cell a cycle; clear
// walks the whole store, one cell a cycle, in ST_INIT. Both sweeps use the
// single memory write port.
// After reset the store is cleared in a pass during which no request is
// taken by the back end.
// While out_stall is high the result is held and requests pile into the
// queue until it fills, then in_stall rises.
// The text_attribute register sits at APB address 0.
`default_nettype none
module text_terminal_scrollback_top
	import tts_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25,
	parameter int HISTORY_LINES = 100
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  req_type,
	input  wire logic [7:0]  char_code,
	input  wire logic [2:0]  scroll_key,
	input  wire logic        ctrl_held,
	input  wire logic [4:0]  view_row,
	input  wire logic [6:0]  view_col,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       cell_char,
	output logic [7:0]       cell_attr,
	output logic [10:0]      cursor_pos,
	output logic             cursor_visible,
	output logic [6:0]       scroll_offset,
	output logic             scrolled_back
);
	localparam logic [1:0] ADDR_ATTR = 2'd0;

	logic [7:0] attr_q;
	logic       q_valid, q_take, busy;
	req_t       q_data;

	// Configuration register.
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_ATTR) ? {24'd0, attr_q} : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= RESET_ATTR;
		end else if (psel && penable && pwrite && paddr == ADDR_ATTR) begin
			attr_q <= pwdata[7:0];
		end
	end

	tts_front #(.COLUMNS(COLUMNS), .ROWS(ROWS), .DEPTH(2)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .req_type, .char_code, .scroll_key,
		.ctrl_held, .view_row, .view_col, .q_valid, .q_data, .q_take
	);

	tts_back #(.COLUMNS(COLUMNS), .ROWS(ROWS), .HISTORY_LINES(HISTORY_LINES)) u_back (
		.clk, .arst_n, .attr(attr_q), .q_valid, .q_data, .q_take, .out_valid,
		.out_stall, .cell_char, .cell_attr, .cursor_pos, .cursor_visible,
		.scroll_offset, .scrolled_back, .busy
	);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(cursor_pos))
		else $error("result dropped under stall");
	a_attr_write: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && paddr == ADDR_ATTR) |=> attr_q == $past(pwdata[7:0]))
		else $error("attribute write lost");
	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> busy) else $error("result outside busy");
endmodule
`default_nettype wire

/* bench/tb_top.sv */
// Self-checking bench for the text terminal scrollback block.
`default_nettype none
module tb_top
	import tts_pkg::*;
();

	localparam int COLS = 80;
	localparam int NROWS = 25;
	localparam int HIST = 100;
	localparam int RING = HIST + NROWS;
	localparam int CYCLE_LIMIT = 3000000;
	localparam logic [1:0] ADDR_TEXT_ATTR = 2'd0;

	typedef struct packed {
		logic [7:0]  cell_char;
		logic [7:0]  cell_attr;
		logic [10:0] cursor_pos;
		logic        cursor_visible;
		logic [6:0]  scroll_offset;
		logic        scrolled_back;
	} term_status_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0, in_stall;
	logic [2:0] req_type = '0;
	logic [7:0] char_code = '0;
	logic [2:0] scroll_key = '0;
	logic ctrl_held = 1'b0;
	logic [4:0] view_row = '0;
	logic [6:0] view_col = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] cell_char, cell_attr;
	logic [10:0] cursor_pos;
	logic cursor_visible, scrolled_back;
	logic [6:0] scroll_offset;

	// Shadow terminal state.
	logic [15:0] shadow_cells [RING*COLS];
	int newest, used, offset, cur_col, cur_row;
	bit history;
	logic [7:0] attr_reg;

	term_status_t expected_status [$];
	int errors = 0;
	int cycles = 0;
	bit stall_free = 1'b0;

	text_terminal_scrollback_top #(.COLUMNS(COLS), .ROWS(NROWS), .HISTORY_LINES(HIST)) DUT (.*);

	always #2 clk = ~clk;

	// Timeout guard.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	function automatic void blank_all(logic [7:0] a);
		for (int i = 0; i < RING*COLS; i++) shadow_cells[i] = {a, BLANK_CHAR};
		newest = 0; used = 1; offset = 0; cur_col = 0; cur_row = 0; history = 0;
	endfunction

	function automatic void open_line();
		newest = (newest + 1) % RING;
		if (used < RING) used++;
		for (int c = 0; c < COLS; c++) shadow_cells[newest*COLS + c] = {attr_reg, BLANK_CHAR};
		cur_row = (used <= NROWS) ? used - 1 : NROWS - 1;
		cur_col = 0; history = 0; offset = 0;
	endfunction

	function automatic void apply_scroll(logic [2:0] key, logic ctrl);
		int lim;
		lim = (used > NROWS) ? used - NROWS : 0;
		case (key)
			KEY_PGUP: if (lim > 0) begin
				history = 1;
				offset = (offset + PAGE_STEP <= lim) ? offset + PAGE_STEP : lim;
			end
			KEY_PGDN: if (history) begin
				if (offset >= PAGE_STEP) offset -= PAGE_STEP;
				else begin offset = 0; history = 0; end
			end
			KEY_UP: if (ctrl && lim > 0) begin
				history = 1;
				if (offset < lim) offset++;
			end
			KEY_DOWN: if (ctrl && history) begin
				if (offset > 0) offset--;
				else history = 0;
			end
			KEY_HOME: if (ctrl && lim > 0) begin history = 1; offset = lim; end
			KEY_END: if (ctrl && history) begin history = 0; offset = 0; end
			default: ;
		endcase
	endfunction

	// Works out the status a request should produce and updates the shadow.
	function automatic term_status_t predict_status(logic [2:0] rt, logic [7:0] ch,
			logic [2:0] key, logic ctrl, logic [4:0] vr, logic [6:0] vc);
		term_status_t s;
		logic [15:0] cell_word;
		int start;
		cell_word = '0;
		case (rt)
			REQ_WRITE: if (ch == NEWLINE_CODE) open_line();
				else begin
					if (cur_col >= COLS) open_line();
					shadow_cells[newest*COLS + cur_col] = {attr_reg, ch};
					cur_col++;
				end
			REQ_BACKSPACE: if (cur_col > 0) begin
				cur_col--;
				shadow_cells[newest*COLS + cur_col] = {attr_reg, BLANK_CHAR};
			end
			REQ_SCROLL: apply_scroll(key, ctrl);
			REQ_READ: if (vr < NROWS && vc < COLS) begin
				start = (used <= NROWS) ? 0 : (newest + 1 + RING - NROWS - offset) % RING;
				cell_word = shadow_cells[((start + vr) % RING)*COLS + vc];
			end
			REQ_CLEAR: blank_all(attr_reg);
			default: ;
		endcase
		s.cell_char = cell_word[7:0];
		s.cell_attr = cell_word[15:8];
		s.cursor_pos = 11'(cur_row*COLS + cur_col);
		s.cursor_visible = !history;
		s.scroll_offset = 7'(offset);
		s.scrolled_back = history;
		return s;
	endfunction

	// Result checker and receiver stalls.
	always @(posedge clk) begin
		term_status_t got, want;
		if (out_valid && !out_stall) begin
			got = '{cell_char, cell_attr, cursor_pos, cursor_visible, scroll_offset, scrolled_back};
			if (expected_status.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
			end else begin
				want = expected_status.pop_front();
				if (got != want) begin
					$display("%0t: mismatch expected %h actual %h", $time, want, got);
					errors++;
				end
			end
		end
		if (stall_free) out_stall <= 1'b0;
		else if ($urandom_range(0, 99) < 8) out_stall <= 1'b1;
		else if ($urandom_range(0, 99) < 60) out_stall <= 1'b0;
	end

	task automatic send_request(logic [2:0] rt, logic [7:0] ch, logic [2:0] key,
			logic ctrl, logic [4:0] vr, logic [6:0] vc);
		int gap;
		gap = ($urandom_range(0, 9) < 7) ? 0 : (($urandom_range(0, 9) < 8) ?
			$urandom_range(1, 3) : $urandom_range(10, 40));
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rt; char_code <= ch; scroll_key <= key;
		ctrl_held <= ctrl; view_row <= vr; view_col <= vc;
		expected_status.push_back(predict_status(rt, ch, key, ctrl, vr, vc));
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_status.size() != 0) @(posedge clk);
		repeat (RING*COLS + 50) @(posedge clk);
	endtask

	task automatic write_attr(logic [7:0] a);
		drain();
		psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_TEXT_ATTR; pwdata <= {24'd0, a};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		attr_reg = a;
	endtask

	task automatic send_random(int count, bit dense_text);
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < (dense_text ? 55 : 30))
				send_request(REQ_WRITE, ($urandom_range(0, 9) == 0) ? NEWLINE_CODE :
					8'($urandom_range(0, 255)), 3'($urandom), 1'($urandom), 5'($urandom),
					7'($urandom));
			else if (r < 40) send_request(REQ_BACKSPACE, 8'($urandom), 3'($urandom),
				1'($urandom), 5'($urandom), 7'($urandom));
			else if (r < 62) send_request(REQ_SCROLL, 8'($urandom), 3'($urandom_range(0, 7)),
				1'($urandom_range(0, 3) != 0), 5'($urandom), 7'($urandom));
			else if (r < 97) send_request(REQ_READ, 8'($urandom), 3'($urandom), 1'($urandom),
				($urandom_range(0, 19) == 0) ? 5'($urandom) : 5'($urandom_range(0, NROWS-1)),
				($urandom_range(0, 19) == 0) ? 7'($urandom) : 7'($urandom_range(0, COLS-1)));
			else if (r < 98) send_request(REQ_CLEAR, 8'($urandom), 3'($urandom), 1'($urandom),
				5'($urandom), 7'($urandom));
			else send_request(3'($urandom_range(5, 7)), 8'($urandom), 3'($urandom),
				1'($urandom), 5'($urandom), 7'($urandom));
		end
	endtask

	// Directed edges: full line, newlines, every scroll key, reads off screen.
	task automatic test_directed();
		send_request(REQ_BACKSPACE, 8'h00, KEY_PGUP, 1'b0, 5'd0, 7'd0);
		send_request(REQ_SCROLL, 8'h00, KEY_PGUP, 1'b1, 5'd0, 7'd0);
		for (int i = 0; i < COLS; i++)
			send_request(REQ_WRITE, (i == 0) ? 8'hFF : 8'(i), KEY_PGUP, 1'b0, 5'd0, 7'd0);
		send_request(REQ_WRITE, 8'h00, KEY_PGUP, 1'b0, 5'd0, 7'd0);
		send_request(REQ_READ, 8'h00, KEY_PGUP, 1'b0, 5'd0, 7'd79);
		send_request(REQ_READ, 8'h00, KEY_PGUP, 1'b0, 5'd31, 7'd127);
		send_request(REQ_READ, 8'h00, KEY_PGUP, 1'b0, 5'd24, 7'd80);
		for (int i = 0; i < 40; i++)
			send_request(REQ_WRITE, NEWLINE_CODE, KEY_PGUP, 1'b0, 5'd0, 7'd0);
		for (int k = 0; k < 8; k++) begin
			send_request(REQ_SCROLL, 8'h00, 3'(k), 1'b0, 5'd0, 7'd0);
			send_request(REQ_SCROLL, 8'h00, 3'(k), 1'b1, 5'd0, 7'd0);
		end
		send_request(REQ_SCROLL, 8'h00, KEY_PGUP, 1'b0, 5'd0, 7'd0);
		send_request(REQ_SCROLL, 8'h00, KEY_PGDN, 1'b0, 5'd0, 7'd0);
		send_request(REQ_WRITE, 8'h41, KEY_PGUP, 1'b0, 5'd0, 7'd0);
		send_request(REQ_READ, 8'h00, KEY_PGUP, 1'b0, 5'd24, 7'd0);
		send_request(3'd7, 8'h00, KEY_PGUP, 1'b0, 5'd0, 7'd0);
		send_request(REQ_CLEAR, 8'h00, KEY_PGUP, 1'b0, 5'd0, 7'd0);
	endtask

	// Deep history: fill past the ring so the line count saturates.
	task automatic test_deep_scroll();
		for (int i = 0; i < 140; i++)
			send_request(REQ_WRITE, NEWLINE_CODE, KEY_PGUP, 1'b0, 5'd0, 7'd0);
		send_request(REQ_SCROLL, 8'h00, KEY_HOME, 1'b1, 5'd0, 7'd0);
		send_request(REQ_SCROLL, 8'h00, KEY_UP, 1'b1, 5'd0, 7'd0);
		send_request(REQ_READ, 8'h00, KEY_PGUP, 1'b0, 5'd0, 7'd0);
		send_random(300, 1'b0);
	endtask

	task automatic test_random_text();
		send_random(450, 1'b1);
		// Hold off until every result is back.
		in_valid <= 1'b0;
		while (expected_status.size() != 0) @(posedge clk);
		send_random(80, 1'b0);
	endtask

	initial begin
		blank_all(RESET_ATTR);
		attr_reg = RESET_ATTR;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		write_attr(8'hFF);
		test_deep_scroll();
		write_attr(8'h00);
		send_request(REQ_CLEAR, 8'h00, KEY_PGUP, 1'b0, 5'd0, 7'd0);
		test_random_text();
		write_attr(8'($urandom));
		send_random(100, 1'b1);
		stall_free = 1'b1;
		drain();
		if (errors == 0) $display("tb_top OK");
		else $display("tb_top NOT OK");
		$finish;
	end
endmodule
`default_nettype wire
